### rtl/mlhc_pkg.sv
package mlhc_pkg;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_THRESHOLD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ON_TIME_MS       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_TIMEOUT_MS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HUE_STEP         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS      = 3'd4;

  localparam logic [9:0]  RST_LIGHT_THRESHOLD  = 10'd50;
  localparam logic [15:0] RST_ON_TIME_MS       = 16'd20000;
  localparam logic [15:0] RST_COLOR_TIMEOUT_MS = 16'd5000;
  localparam logic [8:0]  RST_HUE_STEP         = 9'd15;
  localparam logic [7:0]  RST_DEBOUNCE_MS      = 8'd5;

  // item kinds
  localparam logic [1:0] MODE_TICK   = 2'd0;
  localparam logic [1:0] MODE_ENC    = 2'd1;
  localparam logic [1:0] MODE_MOTION = 2'd2;

  localparam logic [9:0] HUE_WRAP   = 10'd360;
  localparam logic [8:0] SECTOR_DEG = 9'd60;
  localparam logic [7:0] DUTY_FULL  = 8'd255;
  localparam logic [7:0] AGE_MAX    = 8'd255;
  localparam logic [15:0] MS_MAX    = 16'hFFFF;

  typedef enum logic [1:0] {
    PH_SLEEP  = 2'd0,
    PH_AWAKE  = 2'd1,
    PH_SELECT = 2'd2,
    PH_LIT    = 2'd3
  } phase_t;

  typedef struct packed {
    logic [9:0]  light_threshold;
    logic [15:0] on_time_ms;
    logic [15:0] color_timeout_ms;
    logic [8:0]  hue_step;
    logic [7:0]  debounce_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       enc_clk;
    logic       enc_dt;
    logic [9:0] light_level;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [1:0] phase_now;
    logic [8:0] hue_now;
  } out_item_t;

  typedef struct packed {
    phase_t     phase;
    logic [8:0] hue;
  } view_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

endpackage

### rtl/mlhc_in_if.sv
interface mlhc_in_if;
  logic                 valid;
  logic                 ready;
  mlhc_pkg::in_item_t   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/mlhc_out_if.sv
interface mlhc_out_if;
  logic                 valid;
  logic                 ready;
  mlhc_pkg::out_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/mlhc_cfg.sv
module mlhc_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [mlhc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mlhc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output mlhc_pkg::cfg_t                      cfg
);
  import mlhc_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_LIGHT_THRESHOLD:  cfg_nxt.light_threshold  = cfg_wdata[9:0];
        REG_ON_TIME_MS:       cfg_nxt.on_time_ms       = cfg_wdata;
        REG_COLOR_TIMEOUT_MS: cfg_nxt.color_timeout_ms = cfg_wdata;
        REG_HUE_STEP:         cfg_nxt.hue_step         = cfg_wdata[8:0];
        REG_DEBOUNCE_MS:      cfg_nxt.debounce_ms      = cfg_wdata[7:0];
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.light_threshold  <= RST_LIGHT_THRESHOLD;
      cfg_r.on_time_ms       <= RST_ON_TIME_MS;
      cfg_r.color_timeout_ms <= RST_COLOR_TIMEOUT_MS;
      cfg_r.hue_step         <= RST_HUE_STEP;
      cfg_r.debounce_ms      <= RST_DEBOUNCE_MS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### rtl/mlhc_ctrl.sv
module mlhc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  mlhc_pkg::in_item_t   item,
  input  mlhc_pkg::cfg_t       cfg,
  output mlhc_pkg::view_t      view
);
  import mlhc_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [8:0]  hue_r, hue_nxt;
  logic        last_clk_r, last_clk_nxt;
  logic [7:0]  age_r, age_nxt;
  logic [15:0] idle_r, idle_nxt;
  logic [15:0] lit_r, lit_nxt;

  logic [7:0]  age_inc;
  logic [15:0] idle_inc;
  logic        enc_pass;
  logic        enc_rise;
  logic        timed_out;
  logic        lit_done;
  logic [8:0]  step;
  logic [9:0]  hue_up, hue_dn;
  logic [8:0]  hue_stepped;

  assign age_inc   = (age_r == AGE_MAX) ? age_r : age_r + 8'd1;
  assign idle_inc  = (idle_r == MS_MAX) ? idle_r : idle_r + 16'd1;
  assign enc_pass  = (age_r >= cfg.debounce_ms);
  assign enc_rise  = !last_clk_r && item.enc_clk;
  assign timed_out = (idle_inc > cfg.color_timeout_ms);
  assign lit_done  = (lit_r <= 16'd1);

  // hue step reduced mod 360, then wrapped add or subtract
  always_comb begin
    step   = ({1'b0, cfg.hue_step} >= HUE_WRAP) ? 9'(cfg.hue_step - HUE_WRAP[8:0])
                                                : cfg.hue_step;
    hue_up = {1'b0, hue_r} + {1'b0, step};
    hue_dn = {1'b0, hue_r} + HUE_WRAP - {1'b0, step};
    if (item.enc_dt) begin
      hue_stepped = (hue_dn >= HUE_WRAP) ? 9'(hue_dn - HUE_WRAP) : hue_dn[8:0];
    end else begin
      hue_stepped = (hue_up >= HUE_WRAP) ? 9'(hue_up - HUE_WRAP) : hue_up[8:0];
    end
  end

  // phase transitions
  always_comb begin
    phase_nxt = phase_r;
    if (accept) begin
      unique case (item.mode)
        MODE_TICK: begin
          if (phase_r == PH_SELECT && timed_out) begin
            phase_nxt = PH_SLEEP;
          end else if (phase_r == PH_LIT && lit_done) begin
            phase_nxt = PH_SLEEP;
          end
        end
        MODE_ENC: begin
          if (phase_r != PH_LIT && enc_pass) begin
            if (enc_rise) begin
              phase_nxt = PH_SELECT;
            end else if (phase_r == PH_SLEEP) begin
              phase_nxt = PH_AWAKE;
            end
          end
        end
        MODE_MOTION: begin
          if (phase_r == PH_SLEEP && item.light_level < cfg.light_threshold) begin
            phase_nxt = PH_LIT;
          end
        end
        default: phase_nxt = phase_r;
      endcase
    end
  end

  // counters, hue and encoder history
  always_comb begin
    hue_nxt      = hue_r;
    last_clk_nxt = last_clk_r;
    age_nxt      = age_r;
    idle_nxt     = idle_r;
    lit_nxt      = lit_r;
    if (accept) begin
      unique case (item.mode)
        MODE_TICK: begin
          if (phase_r != PH_SLEEP) begin
            age_nxt  = age_inc;
            idle_nxt = idle_inc;
            if (phase_r == PH_SELECT && timed_out) begin
              age_nxt = AGE_MAX;
            end
            if (phase_r == PH_LIT) begin
              if (lit_done) begin
                lit_nxt = '0;
                age_nxt = AGE_MAX;
              end else begin
                lit_nxt = lit_r - 16'd1;
              end
            end
          end
        end
        MODE_ENC: begin
          if (phase_r != PH_LIT && enc_pass) begin
            age_nxt      = '0;
            idle_nxt     = '0;
            last_clk_nxt = item.enc_clk;
            if (enc_rise) begin
              hue_nxt = hue_stepped;
            end
          end
        end
        MODE_MOTION: begin
          if (phase_r == PH_SLEEP) begin
            if (item.light_level < cfg.light_threshold) begin
              lit_nxt = cfg.on_time_ms;
            end else begin
              age_nxt = AGE_MAX;
            end
          end
        end
        default: age_nxt = age_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_SLEEP;
      hue_r      <= '0;
      last_clk_r <= 1'b0;
      age_r      <= AGE_MAX;
      idle_r     <= '0;
      lit_r      <= '0;
    end else begin
      phase_r    <= phase_nxt;
      hue_r      <= hue_nxt;
      last_clk_r <= last_clk_nxt;
      age_r      <= age_nxt;
      idle_r     <= idle_nxt;
      lit_r      <= lit_nxt;
    end
  end

  assign view.phase = phase_r;
  assign view.hue   = hue_r;

endmodule

### rtl/mlhc_wheel.sv
module mlhc_wheel (
  input  mlhc_pkg::view_t  view,
  output mlhc_pkg::rgb_t   rgb
);
  import mlhc_pkg::*;

  logic [8:0] base;
  logic [8:0] offs;
  logic [9:0] scaled;
  logic [7:0] rem;
  logic [2:0] sector;

  // sector search over six 60 degree slices
  always_comb begin
    if (view.hue < SECTOR_DEG) begin
      sector = 3'd0;
    end else if (view.hue < 9'd120) begin
      sector = 3'd1;
    end else if (view.hue < 9'd180) begin
      sector = 3'd2;
    end else if (view.hue < 9'd240) begin
      sector = 3'd3;
    end else if (view.hue < 9'd300) begin
      sector = 3'd4;
    end else begin
      sector = 3'd5;
    end
  end

  // 255/60 == 17/4, so the ramp is (offset * 17) >> 2
  always_comb begin
    base   = 9'(sector * SECTOR_DEG);
    offs   = view.hue - base;
    scaled = {offs[5:0], 4'b0000} + {4'b0000, offs[5:0]};
    rem    = scaled[9:2];
  end

  always_comb begin
    rgb = '0;
    if (view.phase == PH_SELECT || view.phase == PH_LIT) begin
      case (sector)
        3'd0:    rgb = '{red: DUTY_FULL,       green: rem,             blue: 8'd0};
        3'd1:    rgb = '{red: DUTY_FULL - rem, green: DUTY_FULL,       blue: 8'd0};
        3'd2:    rgb = '{red: 8'd0,            green: DUTY_FULL,       blue: rem};
        3'd3:    rgb = '{red: 8'd0,            green: DUTY_FULL - rem, blue: DUTY_FULL};
        3'd4:    rgb = '{red: rem,             green: 8'd0,            blue: DUTY_FULL};
        default: rgb = '{red: DUTY_FULL,       green: 8'd0,            blue: DUTY_FULL - rem};
      endcase
    end
  end

endmodule

### rtl/motion_light_hue_controller.sv
// Motion-activated RGB night light with a rotary-encoder hue selector. Each
// input transaction is a 1 ms tick, an encoder CLK change or a motion rising
// edge, and each yields exactly one output transaction carrying the LED duty
// (red, green, blue), the phase and the hue after the update. A new
// transaction is taken every clock cycle while the output side keeps up: the
// state update is registered on acceptance, the colour wheel works from the
// state registers while the item sits in stage 1, and the output register
// holds the result; a stalled output holds stage 1 and with it the input.
// The feedback through the phase/counter/hue registers sets that rate.
// Configuration registers (index 0 light_threshold, 1 on_time_ms,
// 2 color_timeout_ms, 3 hue_step, 4 debounce_ms) are written through cfg_we,
// cfg_index and cfg_wdata; the user must write them only while the block is
// idle, which the block itself does not enforce; writes to other indexes
// are dropped.
module motion_light_hue_controller (
  input  logic                             clk,
  input  logic                             rst_n,
  mlhc_in_if.sink                          in_chan,
  mlhc_out_if.source                       out_chan,
  input  logic                             cfg_we,
  input  logic [mlhc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mlhc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import mlhc_pkg::*;

  cfg_t      cfg;
  view_t     view;
  rgb_t      rgb;

  logic      in_accept;
  logic      s1_adv;
  logic      s1_valid_r, s1_valid_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r;

  // stage 1 holds the item whose update already sits in the state registers;
  // its result moves to the output register once that slot is free
  assign s1_adv        = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || s1_adv;
  assign in_accept     = in_chan.valid && in_chan.ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  mlhc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // phase machine, counters and hue; state frozen while stage 1 stalls
  mlhc_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (in_accept),
    .item   (in_chan.data),
    .cfg    (cfg),
    .view   (view)
  );

  // hue to duty, zero outside colour select and lit
  mlhc_wheel u_wheel (
    .view (view),
    .rgb  (rgb)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r.red       <= rgb.red;
      out_data_r.green     <= rgb.green;
      out_data_r.blue      <= rgb.blue;
      out_data_r.phase_now <= view.phase;
      out_data_r.hue_now   <= view.hue;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

endmodule

### rtl/mlhc_chk.sv
module mlhc_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] red,
  input logic [7:0] green,
  input logic [7:0] blue,
  input logic [1:0] phase_now,
  input logic [8:0] hue_now
);
  import mlhc_pkg::*;

  // stalled output transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable({red, green, blue, phase_now, hue_now}))
    else $error("output transaction changed while stalled");

  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> hue_now < 9'd360)
    else $error("hue out of range");

  // led dark while asleep or awake idle
  a_dark: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (phase_now == PH_SLEEP || phase_now == PH_AWAKE)
      |-> red == 8'd0 && green == 8'd0 && blue == 8'd0)
    else $error("led lit outside colour select and lit");

  // on the wheel one channel is full and one is off
  a_wheel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (phase_now == PH_SELECT || phase_now == PH_LIT)
      |-> (red == DUTY_FULL || green == DUTY_FULL || blue == DUTY_FULL)
       && (red == 8'd0 || green == 8'd0 || blue == 8'd0))
    else $error("colour off the wheel");

endmodule

bind motion_light_hue_controller mlhc_chk u_mlhc_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .red       (out_chan.data.red),
  .green     (out_chan.data.green),
  .blue      (out_chan.data.blue),
  .phase_now (out_chan.data.phase_now),
  .hue_now   (out_chan.data.hue_now)
);
